// ----- sv/mdbrx_pkg.sv -----
// ----------------------------------------------------------------------------
// mdbrx_pkg
// Types, codes and constants shared by the multidrop-bus block receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdbrx_pkg;

   localparam int MAX_BLOCK = 36;
   localparam int COUNT_W   = 6;

   localparam logic [7:0] ADDR_MASK = 8'hf8;

   localparam logic [7:0] OWN_ADDRESS_RST        = 8'h00;
   localparam logic [7:0] CONTROLLER_ADDRESS_RST = 8'h00;
   localparam logic [7:0] ACK_CODE_RST           = 8'h00;
   localparam logic [7:0] RET_CODE_RST           = 8'haa;
   localparam logic [7:0] NAK_CODE_RST           = 8'hff;

   typedef enum logic [2:0] {
      REG_OWN_ADDRESS        = 3'd0,
      REG_CONTROLLER_ADDRESS = 3'd1,
      REG_ACK_CODE           = 3'd2,
      REG_RET_CODE           = 3'd3,
      REG_NAK_CODE           = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      EV_WORD       = 2'd0,
      EV_RESP_TO    = 2'd1,
      EV_BYTE_TO    = 2'd2,
      EV_START      = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_FIRST = 3'b010,
      PH_BLOCK = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACK        = 3'd0,
      ST_NAK        = 3'd1,
      ST_RET        = 3'd2,
      ST_NORESP     = 3'd3,
      ST_IGNORED    = 3'd4,
      ST_RECEIVED   = 3'd5,
      ST_DISORDERED = 3'd6,
      ST_DISTORTED  = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] controller_address;
      logic [7:0] ack_code;
      logic [7:0] ret_code;
      logic [7:0] nak_code;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] word_count;
      logic [7:0]         running_sum;
      logic [8:0]         last_word;
   } state_type;

   typedef struct packed {
      logic               verdict_valid;
      logic [2:0]         status;
      logic               byte_valid;
      logic [COUNT_W-1:0] byte_index;
      logic [7:0]         byte_value;
      logic               byte_flag;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/mdbrx_step.sv -----
// ----------------------------------------------------------------------------
// mdbrx_step
// Per-event decision logic: next receiver state and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdbrx_step
   import mdbrx_pkg::*;
(
   input  wire cfg_type    cfg,
   input  wire state_type  cur,
   input  wire event_type  ev,
   input  wire [7:0]       word_data,
   input  wire             word_flag,
   output state_type       nxt,
   output result_type      res
);

   logic               ctrl;
   logic [COUNT_W:0]   next_count;

   assign ctrl       = (cfg.own_address == cfg.controller_address);
   assign next_count = {1'b0, cur.word_count} + (COUNT_W+1)'(1);

   always_comb begin
      nxt = cur;
      res = '0;
      if (ev == EV_START) begin
         nxt.phase       = PH_FIRST;
         nxt.word_count  = '0;
         nxt.running_sum = '0;
         nxt.last_word   = '0;
      end else begin
         case (cur.phase)
            PH_FIRST: begin
               if (ev == EV_RESP_TO) begin
                  res.verdict_valid = 1'b1;
                  res.status        = ST_NORESP;
                  nxt.phase         = PH_IDLE;
               end else if (ev == EV_WORD) begin
                  res.byte_valid  = 1'b1;
                  res.byte_index  = '0;
                  res.byte_value  = word_data;
                  res.byte_flag   = word_flag;
                  nxt.word_count  = '0;
                  nxt.last_word   = {word_flag, word_data};
                  nxt.running_sum = '0;
                  res.verdict_valid = 1'b1;
                  nxt.phase         = PH_IDLE;
                  if (word_data == cfg.ack_code) begin
                     res.status = ST_ACK;
                  end else if (word_data == cfg.ret_code) begin
                     res.status = ST_RET;
                  end else if (word_data == cfg.nak_code) begin
                     res.status = ST_NAK;
                  end else if (word_flag) begin
                     if (ctrl) begin
                        res.status = ST_DISORDERED;
                     end else if ((word_data & ADDR_MASK) != cfg.own_address) begin
                        res.status = ST_IGNORED;
                     end else begin
                        res.verdict_valid = 1'b0;
                        nxt.phase         = PH_BLOCK;
                     end
                  end else begin
                     if (!ctrl) begin
                        res.status = ST_DISORDERED;
                     end else begin
                        res.verdict_valid = 1'b0;
                        nxt.phase         = PH_BLOCK;
                     end
                  end
               end
            end
            PH_BLOCK: begin
               if (ev == EV_WORD) begin
                  if (next_count >= (COUNT_W+1)'(MAX_BLOCK)) begin
                     res.verdict_valid = 1'b1;
                     res.status        = ST_DISORDERED;
                     nxt.phase         = PH_IDLE;
                  end else begin
                     nxt.running_sum = cur.running_sum + cur.last_word[7:0];
                     nxt.word_count  = next_count[COUNT_W-1:0];
                     nxt.last_word   = {word_flag, word_data};
                     res.byte_valid  = 1'b1;
                     res.byte_index  = next_count[COUNT_W-1:0];
                     res.byte_value  = word_data;
                     res.byte_flag   = word_flag;
                  end
               end else if (ev == EV_BYTE_TO) begin
                  res.verdict_valid = 1'b1;
                  nxt.phase         = PH_IDLE;
                  if (cur.running_sum != cur.last_word[7:0]) begin
                     res.status = ST_DISTORTED;
                  end else if (cur.last_word[8] != ctrl) begin
                     res.status = ST_DISORDERED;
                  end else begin
                     res.status = ST_RECEIVED;
                  end
               end
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- sv/mdb_block_receiver.sv -----
// ----------------------------------------------------------------------------
// mdb_block_receiver
// Multidrop-bus 9-bit block receiver: one event beat in, one result beat out.
// ----------------------------------------------------------------------------
// Each accepted req beat yields its rsp beat from a register, valid in the next cycle.
// Throughput: 1 event per cycle while rsp is ready; the result register is refilled in the cycle
// it is drained.
// Reset: receiver goes idle, registers take their defaults, rsp is empty.
`timescale 1ns / 1ps
`default_nettype none

module mdb_block_receiver
   import mdbrx_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] word_data
   input  wire  [2:0]  req_tuser,   // [1:0] event, [2] word_flag
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] byte_index, [13:6] byte_value, [15:14] zero
   output logic [5:0]  rsp_tuser,   // [0] verdict_valid, [3:1] status, [4] byte_valid,
                                    // [5] byte_flag
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   state_type     state_ff;
   state_type     state_in;
   result_type    res_ff;
   result_type    res_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_acc;
   logic          csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_OWN_ADDRESS:        cfg_in.own_address        = csr_pwdata[7:0];
            REG_CONTROLLER_ADDRESS: cfg_in.controller_address = csr_pwdata[7:0];
            REG_ACK_CODE:           cfg_in.ack_code           = csr_pwdata[7:0];
            REG_RET_CODE:           cfg_in.ret_code           = csr_pwdata[7:0];
            REG_NAK_CODE:           cfg_in.nak_code           = csr_pwdata[7:0];
            default:                cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_OWN_ADDRESS:        csr_prdata = {24'd0, cfg_ff.own_address};
         REG_CONTROLLER_ADDRESS: csr_prdata = {24'd0, cfg_ff.controller_address};
         REG_ACK_CODE:           csr_prdata = {24'd0, cfg_ff.ack_code};
         REG_RET_CODE:           csr_prdata = {24'd0, cfg_ff.ret_code};
         REG_NAK_CODE:           csr_prdata = {24'd0, cfg_ff.nak_code};
         default:                csr_prdata = '0;
      endcase
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_acc    = req_tvalid & req_tready;

   state_type  step_nxt;
   result_type step_res;

   mdbrx_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .ev        (event_type'(req_tuser[1:0])),
      .word_data (req_tdata),
      .word_flag (req_tuser[2]),
      .nxt       (step_nxt),
      .res       (step_res)
   );

   assign state_in     = req_acc ? step_nxt : state_ff;
   assign res_in       = req_acc ? step_res : res_ff;
   assign rsp_valid_in = req_acc | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address        <= OWN_ADDRESS_RST;
         cfg_ff.controller_address <= CONTROLLER_ADDRESS_RST;
         cfg_ff.ack_code           <= ACK_CODE_RST;
         cfg_ff.ret_code           <= RET_CODE_RST;
         cfg_ff.nak_code           <= NAK_CODE_RST;
         state_ff.phase            <= PH_IDLE;
         state_ff.word_count       <= '0;
         state_ff.running_sum      <= '0;
         state_ff.last_word        <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.byte_value, res_ff.byte_index};
   assign rsp_tuser  = {res_ff.byte_flag, res_ff.byte_valid, res_ff.status,
                        res_ff.verdict_valid};

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[1:0] == EV_START) |=>
         (rsp_tvalid && rsp_tdata == '0 && rsp_tuser == '0 && state_ff.phase == PH_FIRST))
      else $error("start beat did not clear the result and state");

   a_verdict_idles: assert property (@(posedge clock) disable iff (reset)
      (req_acc && step_res.verdict_valid) |=> (state_ff.phase == PH_IDLE))
      else $error("verdict left receiver out of idle");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[4]) |->
         ({1'b0, rsp_tdata[5:0]} < (COUNT_W+1)'(MAX_BLOCK)))
      else $error("stored word index beyond block size");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.word_count} < (COUNT_W+1)'(MAX_BLOCK))
      else $error("word count beyond block size");

endmodule

`default_nettype wire

// ----- sim/mdb_block_receiver_test.sv -----
// ----------------------------------------------------------------------------
// mdb_block_receiver_test
// Self-checking bench for the multidrop-bus block receiver. Event beats go in
// on req, one result beat per event comes back on rsp and is compared field
// by field against an in-bench prediction. Several register settings are
// run, for controller and peripheral roles. Each setting gets random
// exchanges (response words, good and corrupted blocks, overlong blocks,
// timeouts, noise) and some get directed ones as well, with random gaps on
// both sides and one long rsp back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdb_block_receiver_test;
   import mdbrx_pkg::*;

   class block_scoreboard;
      cfg_type    regs;
      phase_type  phase;
      logic [5:0] word_count;
      logic [7:0] running_sum;
      logic [8:0] last_word;
      result_type pending_results[$];
      int         errors;
      int         beats_checked;
      int         words_stored;
      int         verdicts[8];

      function new();
         regs = {OWN_ADDRESS_RST, CONTROLLER_ADDRESS_RST, ACK_CODE_RST, RET_CODE_RST,
                 NAK_CODE_RST};
         phase = PH_IDLE;
         word_count = '0;
         running_sum = '0;
         last_word = '0;
         errors = 0;
         beats_checked = 0;
         words_stored = 0;
         foreach (verdicts[i]) verdicts[i] = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [7:0] value);
         case (idx)
            REG_OWN_ADDRESS:        regs.own_address = value;
            REG_CONTROLLER_ADDRESS: regs.controller_address = value;
            REG_ACK_CODE:           regs.ack_code = value;
            REG_RET_CODE:           regs.ret_code = value;
            REG_NAK_CODE:           regs.nak_code = value;
            default: ;
         endcase
      endfunction

      function void conclude(inout result_type r, input status_type s);
         r.verdict_valid = 1'b1;
         r.status = s;
         phase = PH_IDLE;
      endfunction

      function void keep_word(inout result_type r, input logic [5:0] idx,
                              input logic [7:0] data, input logic flag);
         r.byte_valid = 1'b1;
         r.byte_index = idx;
         r.byte_value = data;
         r.byte_flag = flag;
         word_count = idx;
         last_word = {flag, data};
      endfunction

      function void note_event(event_type ev, logic [7:0] data, logic flag);
         result_type r;
         logic ctrl;
         r = '0;
         ctrl = (regs.own_address == regs.controller_address);
         if (ev == EV_START) begin
            phase = PH_FIRST;
            word_count = '0;
            running_sum = '0;
            last_word = '0;
         end else if (phase == PH_FIRST) begin
            if (ev == EV_RESP_TO) begin
               conclude(r, ST_NORESP);
            end else if (ev == EV_WORD) begin
               keep_word(r, 6'd0, data, flag);
               running_sum = '0;
               if (data == regs.ack_code) conclude(r, ST_ACK);
               else if (data == regs.ret_code) conclude(r, ST_RET);
               else if (data == regs.nak_code) conclude(r, ST_NAK);
               else if (flag) begin
                  if (ctrl) conclude(r, ST_DISORDERED);
                  else if ((data & ADDR_MASK) != regs.own_address) conclude(r, ST_IGNORED);
                  else phase = PH_BLOCK;
               end else if (!ctrl) begin
                  conclude(r, ST_DISORDERED);
               end else begin
                  phase = PH_BLOCK;
               end
            end
         end else if (phase == PH_BLOCK) begin
            if (ev == EV_WORD) begin
               if (int'(word_count) + 1 >= MAX_BLOCK) begin
                  conclude(r, ST_DISORDERED);
               end else begin
                  running_sum = running_sum + last_word[7:0];
                  keep_word(r, word_count + 6'd1, data, flag);
               end
            end else if (ev == EV_BYTE_TO) begin
               if (running_sum != last_word[7:0]) conclude(r, ST_DISTORTED);
               else if (last_word[8] != ctrl) conclude(r, ST_DISORDERED);
               else conclude(r, ST_RECEIVED);
            end
         end else begin
            phase = PH_IDLE;
         end
         pending_results.push_back(r);
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(logic [15:0] tdata, logic [5:0] tuser);
         result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: rsp beat tdata=%h tuser=%h with nothing expected",
                     $time, tdata, tuser);
            return;
         end
         want = pending_results.pop_front();
         beats_checked++;
         if (want.verdict_valid) verdicts[want.status]++;
         if (want.byte_valid) words_stored++;
         compare("verdict_valid", want.verdict_valid, tuser[0]);
         compare("status", want.status, tuser[3:1]);
         compare("byte_valid", want.byte_valid, tuser[4]);
         compare("byte_flag", want.byte_flag, tuser[5]);
         compare("byte_index", want.byte_index, tdata[5:0]);
         compare("byte_value", want.byte_value, tdata[13:6]);
         compare("tdata pad", 0, tdata[15:14]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] word_data
   logic [2:0]  req_tuser = '0;   // [1:0] event, [2] word_flag
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [5:0] byte_index, [13:6] byte_value, [15:14] zero
   logic [5:0]  rsp_tuser;        // [0] verdict_valid, [3:1] status, [4] byte_valid,
                                  // [5] byte_flag
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   block_scoreboard sb;
   cfg_type         active_cfg;
   cfg_type         plan[6];
   int              beats_sent = 0;
   bit              req_parked = 1'b1;
   bit              no_gaps = 1'b0;
   bit              sender_burst = 1'b0;
   bit              want_hold = 1'b0;

   mdb_block_receiver uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("%0t: timeout", $time);
      $display("** mdb_block_receiver: FAILED **");
      $finish;
   end

   // result side: random stall per beat, one long hold on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (want_hold) begin
            want_hold = 1'b0;
            stall = 150;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   task automatic send_event(input event_type ev, input logic [7:0] data, input logic flag);
      int gap;
      gap = (no_gaps || sender_burst) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         if (!req_parked) req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= {flag, ev};
      req_parked = 1'b0;
      do @(posedge clock); while (!req_tready);
      sb.note_event(ev, data, flag);
      beats_sent++;
   endtask

   task automatic wait_drained();
      if (!req_parked) begin
         req_tvalid <= 1'b0;
         req_parked = 1'b1;
      end
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_config(input cfg_type c);
      csr_write(REG_OWN_ADDRESS, c.own_address);
      csr_write(REG_CONTROLLER_ADDRESS, c.controller_address);
      csr_write(REG_ACK_CODE, c.ack_code);
      csr_write(REG_RET_CODE, c.ret_code);
      csr_write(REG_NAK_CODE, c.nak_code);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      active_cfg = c;
      @(posedge clock);
   endtask

   // start, first word by role, body and check words (or an overlong run of
   // random words), inter-byte timeout; mostly well formed, some corrupted
   task automatic run_block(input bit overlong);
      logic [7:0] d;
      logic [7:0] total;
      logic       f;
      bit         ctrl;
      int         body;
      ctrl = (active_cfg.own_address == active_cfg.controller_address);
      send_event(EV_START, 8'($urandom), 1'($urandom));
      if (ctrl) begin
         d = 8'($urandom);
         f = 1'b0;
      end else begin
         d = {active_cfg.own_address[7:3], 3'($urandom)};
         f = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) f = ~f;
      send_event(EV_WORD, d, f);
      total = d;
      if (overlong) begin
         repeat (MAX_BLOCK) send_event(EV_WORD, 8'($urandom), 1'($urandom));
      end else begin
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_BLOCK - 2)
                                            : $urandom_range(0, 5);
         repeat (body) begin
            d = 8'($urandom);
            send_event(EV_WORD, d, 1'($urandom));
            total = total + d;
            if ($urandom_range(0, 7) == 0) send_event(EV_RESP_TO, 8'($urandom), 1'($urandom));
         end
         d = total;
         if ($urandom_range(0, 7) == 0) d = d ^ 8'($urandom_range(1, 255));
         f = ctrl;
         if ($urandom_range(0, 7) == 0) f = ~f;
         send_event(EV_WORD, d, f);
      end
      send_event(EV_BYTE_TO, 8'($urandom), 1'($urandom));
   endtask

   task automatic run_random_exchange();
      int unsigned pick;
      logic [7:0]  code;
      pick = $urandom_range(0, 99);
      if (pick < 56) begin
         run_block(1'b0);
      end else if (pick < 58) begin
         run_block(1'b1);
      end else if (pick < 72) begin
         case ($urandom_range(0, 2))
            0: code = active_cfg.ack_code;
            1: code = active_cfg.ret_code;
            default: code = active_cfg.nak_code;
         endcase
         send_event(EV_START, 8'($urandom), 1'($urandom));
         send_event(EV_WORD, code, 1'($urandom));
      end else if (pick < 82) begin
         send_event(EV_START, 8'($urandom), 1'($urandom));
         if ($urandom_range(0, 1)) send_event(EV_BYTE_TO, 8'($urandom), 1'($urandom));
         send_event(EV_RESP_TO, 8'($urandom), 1'($urandom));
      end else begin
         repeat ($urandom_range(1, 4))
            send_event(event_type'(2'($urandom_range(0, 3))), 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int target;
      int waited;
      sb = new();
      // own, controller, ack, ret, nak
      plan[0] = {8'h00, 8'h00, 8'h00, 8'haa, 8'hff};
      plan[1] = {8'h28, 8'h00, 8'h11, 8'h22, 8'h33};
      plan[2] = {8'hff, 8'hff, 8'hff, 8'h00, 8'h80};
      plan[3] = {8'hf8, 8'h07, 8'h00, 8'h00, 8'h00};
      plan[4] = {8'h00, 8'hff, 8'hfe, 8'hfd, 8'hfc};
      plan[5] = {8'h0f, 8'h00, 8'h5a, 8'ha5, 8'h3c};
      active_cfg = plan[0];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // controller role at reset settings
      send_event(EV_WORD, 8'h5a, 1'b1);
      send_event(EV_RESP_TO, 8'h00, 1'b0);
      send_event(EV_BYTE_TO, 8'hff, 1'b1);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_BYTE_TO, 8'h00, 1'b0);
      send_event(EV_RESP_TO, 8'h00, 1'b0);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h00, 1'b0);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'haa, 1'b1);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'hff, 1'b1);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h81, 1'b1);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h12, 1'b0);
      send_event(EV_WORD, 8'h34, 1'b0);
      send_event(EV_RESP_TO, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h46, 1'b1);
      send_event(EV_BYTE_TO, 8'h00, 1'b0);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h01, 1'b0);
      send_event(EV_WORD, 8'h01, 1'b0);
      send_event(EV_BYTE_TO, 8'h00, 1'b0);
      send_event(EV_START, 8'h00, 1'b0);
      send_event(EV_WORD, 8'h7f, 1'b0);
      send_event(EV_WORD, 8'h00, 1'b1);
      send_event(EV_BYTE_TO, 8'h00, 1'b0);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         apply_config(plan[p]);
         no_gaps = (p == 4);
         sender_burst = (p == 2);
         if (p == 2) want_hold = 1'b1;
         if (p == 0) run_block(1'b1);
         if (p == 1) begin
            // peripheral role: address mismatch, clear mode bit, good block
            send_event(EV_START, 8'h00, 1'b0);
            send_event(EV_WORD, 8'h30, 1'b1);
            send_event(EV_START, 8'h00, 1'b0);
            send_event(EV_WORD, 8'h2b, 1'b0);
            send_event(EV_START, 8'h00, 1'b0);
            send_event(EV_WORD, 8'h2d, 1'b1);
            send_event(EV_WORD, 8'h10, 1'b1);
            send_event(EV_WORD, 8'h3d, 1'b0);
            send_event(EV_BYTE_TO, 8'h00, 1'b0);
         end
         target = beats_sent + 60;
         while (beats_sent < target) run_random_exchange();
         sender_burst = 1'b0;
      end

      if (!req_parked) begin
         req_tvalid <= 1'b0;
         req_parked = 1'b1;
      end
      waited = 0;
      while (sb.pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time,
                  sb.pending_results.size());
      end

      $display("Run covered %0d events over 6 register settings, %0d words stored.",
               sb.beats_checked, sb.words_stored);
      $display("Verdicts ack %0d nak %0d ret %0d noresp %0d ignored %0d received %0d",
               sb.verdicts[ST_ACK], sb.verdicts[ST_NAK], sb.verdicts[ST_RET],
               sb.verdicts[ST_NORESP], sb.verdicts[ST_IGNORED], sb.verdicts[ST_RECEIVED]);
      $display("  disordered %0d distorted %0d, mismatches %0d",
               sb.verdicts[ST_DISORDERED], sb.verdicts[ST_DISTORTED], sb.errors);
      if (sb.errors == 0) begin
         $display("** mdb_block_receiver: PASSED **");
      end else begin
         $display("** mdb_block_receiver: FAILED **");
      end
      $finish;
   end

endmodule
